>>> rtl/multi_queue_linked_node_pool_defines.svh
// Assertion macros for the linked node pool.
`ifndef MULTI_QUEUE_LINKED_NODE_POOL_DEFINES_SVH
`define MULTI_QUEUE_LINKED_NODE_POOL_DEFINES_SVH

`ifndef ASSERT_OFF

`define MQLNP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: property violated");

`define MQLNP_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("%m: forbidden condition seen");

`else

`define MQLNP_ASSERT(lbl, clk, rstn, prop)

`define MQLNP_ASSERT_NEVER(lbl, clk, rstn, prop)

`endif

`endif

>>> rtl/mqlnp_pkg.sv
package mqlnp_pkg;

  localparam int unsigned NODES_DEF  = 32;
  localparam int unsigned QUEUES_DEF = 4;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned QID_W    = 2;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned MASK_W   = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ    = 2'd0,
    FUNC_DEQ    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_PEEK   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QRD,
    S_ALLOC,
    S_APPEND,
    S_WALK,
    S_INS,
    S_INS2,
    S_UNLINK,
    S_FREE,
    S_HEAD,
    S_QWR,
    S_DONE
  } state_e;

endpackage

>>> rtl/mqlnp_ram.sv
module mqlnp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/multi_queue_linked_node_pool.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------------
// input    | in_valid_i / in_ready_o | func_i, queue_id_i, data_tag_i, sort_key_i
// output   | out_valid_o/out_ready_i | status_o, data_out_o, key_out_o, count_o
// config   | cfg_we_i                | cfg_wdata_i (ordered_mask)
//
// One transaction at a time. Failures at the queue read end the transaction there; peek,
// dequeue and enqueue into an empty or FIFO queue need no walk. Sorted insert and remove
// walk the list node by node: the walk does one link and one tag/key memory read per cycle.
// Reset takes effect at once: unused nodes are handed out in descending order
// by a counter, so the link memory needs no clearing pass.
// A finished result waits in the output register; a new transaction is taken
// while it waits, and its own result holds until the register frees.
module multi_queue_linked_node_pool #(
  parameter int unsigned NODES  = mqlnp_pkg::NODES_DEF,
  parameter int unsigned QUEUES = mqlnp_pkg::QUEUES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mqlnp_pkg::FUNC_W-1:0]      func_i,
  input  logic [mqlnp_pkg::QID_W-1:0]       queue_id_i,
  input  logic [mqlnp_pkg::TAG_W-1:0]       data_tag_i,
  input  logic [mqlnp_pkg::KEY_W-1:0]       sort_key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mqlnp_pkg::STATUS_W-1:0]    status_o,
  output logic [mqlnp_pkg::TAG_W-1:0]       data_out_o,
  output logic [mqlnp_pkg::KEY_W-1:0]       key_out_o,
  output logic [mqlnp_pkg::COUNT_W-1:0]     count_o,
  input  logic                              cfg_we_i,
  input  logic [mqlnp_pkg::MASK_W-1:0]      cfg_wdata_i
);

`include "multi_queue_linked_node_pool_defines.svh"

  localparam int unsigned NW  = $clog2(NODES + 1);
  localparam int unsigned AW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned DW  = mqlnp_pkg::TAG_W + mqlnp_pkg::KEY_W;
  localparam int unsigned QRW = 3 * NW;
  localparam logic [NW-1:0] NIL = NW'(NODES);

  function automatic logic [1:0] wrap_queue(input logic [1:0] v);
    logic [1:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (32'(r) >= QUEUES) begin
        r = r - 2'(QUEUES);
      end
    end
    return r;
  endfunction

  mqlnp_pkg::state_e  state_q, state_d;
  mqlnp_pkg::func_e   func_q;
  mqlnp_pkg::status_e status_q, status_d;

  logic [1:0]                   q2_q;
  logic [mqlnp_pkg::TAG_W-1:0]  tag_q;
  logic [mqlnp_pkg::KEY_W-1:0]  key_q;
  logic [NW-1:0] qh_q, qh_d, qt_q, qt_d, qc_q, qc_d;
  logic [NW-1:0] nn_q, nn_d, cur_q, cur_d, prev_q, prev_d, nxt_q, nxt_d;
  logic [NW-1:0] free_head_q, free_head_d, fresh_q, fresh_d;
  logic [QUEUES-1:0]            qvalid_q;
  logic [mqlnp_pkg::MASK_W-1:0] mask_q;
  logic [mqlnp_pkg::TAG_W-1:0]  dout_q, dout_d;
  logic [mqlnp_pkg::KEY_W-1:0]  kout_q, kout_d;

  logic                           out_valid_q;
  logic [mqlnp_pkg::STATUS_W-1:0] out_status_q;
  logic [mqlnp_pkg::TAG_W-1:0]    out_dout_q;
  logic [mqlnp_pkg::KEY_W-1:0]    out_kout_q;
  logic [mqlnp_pkg::COUNT_W-1:0]  out_count_q;

  logic          accept;
  logic          out_free;
  logic [QW-1:0] qa_in, qa_q;

  // memory ports
  logic          link_we;
  logic [AW-1:0] link_waddr, link_raddr;
  logic [NW-1:0] link_wdata, link_rdata;
  logic          data_we;
  logic [AW-1:0] data_waddr, data_raddr;
  logic [DW-1:0] data_wdata, data_rdata;
  logic          qram_we;
  logic [QW-1:0] qram_raddr;
  logic [QRW-1:0] qram_wdata, qram_rdata;

  logic [NW-1:0] qh_rd, qt_rd, qc_rd;
  logic [mqlnp_pkg::TAG_W-1:0] tag_cur;
  logic [mqlnp_pkg::KEY_W-1:0] key_cur;
  logic          ordered;
  logic          is_fresh;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign qa_in    = QW'(wrap_queue(queue_id_i));
  assign qa_q     = QW'(q2_q);
  assign ordered  = mask_q[q2_q];
  assign is_fresh = nn_q < fresh_q;

  assign qh_rd = qvalid_q[qa_q] ? qram_rdata[3*NW-1:2*NW] : NIL;
  assign qt_rd = qvalid_q[qa_q] ? qram_rdata[2*NW-1:NW]   : NIL;
  assign qc_rd = qvalid_q[qa_q] ? qram_rdata[NW-1:0]      : '0;

  assign tag_cur = data_rdata[DW-1:mqlnp_pkg::KEY_W];
  assign key_cur = data_rdata[mqlnp_pkg::KEY_W-1:0];

  assign qram_wdata = {qh_q, qt_q, qc_q};

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    qh_d        = qh_q;
    qt_d        = qt_q;
    qc_d        = qc_q;
    nn_d        = nn_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    dout_d      = dout_q;
    kout_d      = kout_q;
    in_ready_o  = 1'b0;
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = NIL;
    link_raddr  = cur_q[AW-1:0];
    data_we     = 1'b0;
    data_waddr  = nn_q[AW-1:0];
    data_wdata  = {tag_q, key_q};
    data_raddr  = cur_q[AW-1:0];
    qram_we     = 1'b0;
    qram_raddr  = qa_q;

    unique case (state_q)
      mqlnp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        qram_raddr = qa_in;
        if (in_valid_i) begin
          dout_d  = '0;
          kout_d  = '0;
          state_d = mqlnp_pkg::S_QRD;
        end
      end
      mqlnp_pkg::S_QRD: begin
        qh_d     = qh_rd;
        qt_d     = qt_rd;
        qc_d     = qc_rd;
        status_d = mqlnp_pkg::ST_OK;
        unique case (func_q)
          mqlnp_pkg::FUNC_ENQ: begin
            if (free_head_q == NIL) begin
              status_d = mqlnp_pkg::ST_NO_FREE;
              state_d  = mqlnp_pkg::S_DONE;
            end else begin
              nn_d       = free_head_q;
              link_raddr = free_head_q[AW-1:0];
              state_d    = mqlnp_pkg::S_ALLOC;
            end
          end
          mqlnp_pkg::FUNC_REMOVE: begin
            if (qc_rd == '0) begin
              status_d = mqlnp_pkg::ST_NOT_FOUND;
              state_d  = mqlnp_pkg::S_DONE;
            end else begin
              cur_d      = qh_rd;
              prev_d     = NIL;
              link_raddr = qh_rd[AW-1:0];
              data_raddr = qh_rd[AW-1:0];
              state_d    = mqlnp_pkg::S_WALK;
            end
          end
          default: begin
            if (qc_rd == '0) begin
              status_d = mqlnp_pkg::ST_EMPTY;
              state_d  = mqlnp_pkg::S_DONE;
            end else begin
              link_raddr = qh_rd[AW-1:0];
              data_raddr = qh_rd[AW-1:0];
              state_d    = mqlnp_pkg::S_HEAD;
            end
          end
        endcase
      end
      mqlnp_pkg::S_ALLOC: begin
        // never-used nodes come off in descending order without a link read
        if (is_fresh) begin
          free_head_d = (nn_q == '0) ? NIL : NW'(nn_q - 1'b1);
          fresh_d     = NW'(fresh_q - 1'b1);
        end else begin
          free_head_d = link_rdata;
        end
        data_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = nn_q[AW-1:0];
        link_wdata = NIL;
        if (qc_q == '0) begin
          qh_d    = nn_q;
          qt_d    = nn_q;
          qc_d    = NW'(1);
          state_d = mqlnp_pkg::S_QWR;
        end else if (!ordered) begin
          state_d = mqlnp_pkg::S_APPEND;
        end else begin
          cur_d      = qh_q;
          prev_d     = NIL;
          link_raddr = qh_q[AW-1:0];
          data_raddr = qh_q[AW-1:0];
          state_d    = mqlnp_pkg::S_WALK;
        end
      end
      mqlnp_pkg::S_APPEND: begin
        link_we    = 1'b1;
        link_waddr = qt_q[AW-1:0];
        link_wdata = nn_q;
        qt_d       = nn_q;
        qc_d       = NW'(qc_q + 1'b1);
        state_d    = mqlnp_pkg::S_QWR;
      end
      mqlnp_pkg::S_WALK: begin
        if (func_q == mqlnp_pkg::FUNC_ENQ) begin
          if (key_q >= key_cur) begin
            prev_d     = cur_q;
            cur_d      = link_rdata;
            link_raddr = link_rdata[AW-1:0];
            data_raddr = link_rdata[AW-1:0];
            if (link_rdata == NIL) begin
              state_d = mqlnp_pkg::S_INS;
            end
          end else begin
            state_d = mqlnp_pkg::S_INS;
          end
        end else begin
          if (tag_cur == tag_q) begin
            nxt_d   = link_rdata;
            state_d = mqlnp_pkg::S_UNLINK;
          end else if (link_rdata == NIL) begin
            status_d = mqlnp_pkg::ST_NOT_FOUND;
            state_d  = mqlnp_pkg::S_DONE;
          end else begin
            prev_d     = cur_q;
            cur_d      = link_rdata;
            link_raddr = link_rdata[AW-1:0];
            data_raddr = link_rdata[AW-1:0];
          end
        end
      end
      mqlnp_pkg::S_INS: begin
        link_we    = 1'b1;
        link_waddr = nn_q[AW-1:0];
        link_wdata = cur_q;
        state_d    = mqlnp_pkg::S_INS2;
      end
      mqlnp_pkg::S_INS2: begin
        if (prev_q == NIL) begin
          qh_d = nn_q;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_q[AW-1:0];
          link_wdata = nn_q;
        end
        if (cur_q == NIL) begin
          qt_d = nn_q;
        end
        qc_d    = NW'(qc_q + 1'b1);
        state_d = mqlnp_pkg::S_QWR;
      end
      mqlnp_pkg::S_UNLINK: begin
        if (prev_q == NIL) begin
          qh_d = nxt_q;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_q[AW-1:0];
          link_wdata = nxt_q;
        end
        if (qt_q == cur_q) begin
          qt_d = prev_q;
        end
        qc_d    = NW'(qc_q - 1'b1);
        state_d = mqlnp_pkg::S_FREE;
      end
      mqlnp_pkg::S_FREE: begin
        link_we     = 1'b1;
        link_waddr  = cur_q[AW-1:0];
        link_wdata  = free_head_q;
        free_head_d = cur_q;
        state_d     = mqlnp_pkg::S_QWR;
      end
      mqlnp_pkg::S_HEAD: begin
        dout_d = tag_cur;
        kout_d = key_cur;
        if (func_q == mqlnp_pkg::FUNC_DEQ) begin
          qh_d = link_rdata;
          qc_d = NW'(qc_q - 1'b1);
          if (link_rdata == NIL) begin
            qt_d = NIL;
            qc_d = '0;
          end
          link_we     = 1'b1;
          link_waddr  = qh_q[AW-1:0];
          link_wdata  = free_head_q;
          free_head_d = qh_q;
          state_d     = mqlnp_pkg::S_QWR;
        end else begin
          state_d = mqlnp_pkg::S_DONE;
        end
      end
      mqlnp_pkg::S_QWR: begin
        qram_we = 1'b1;
        state_d = mqlnp_pkg::S_DONE;
      end
      mqlnp_pkg::S_DONE: begin
        if (out_free) begin
          state_d = mqlnp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mqlnp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mqlnp_pkg::S_IDLE;
      free_head_q <= NW'(NODES - 1);
      fresh_q     <= NIL;
      qvalid_q    <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (qram_we) begin
        qvalid_q[qa_q] <= 1'b1;
      end
      if (state_q == mqlnp_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= mqlnp_pkg::func_e'(func_i);
      q2_q   <= wrap_queue(queue_id_i);
      tag_q  <= data_tag_i;
      key_q  <= sort_key_i;
    end
    status_q <= status_d;
    qh_q     <= qh_d;
    qt_q     <= qt_d;
    qc_q     <= qc_d;
    nn_q     <= nn_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    nxt_q    <= nxt_d;
    dout_q   <= dout_d;
    kout_q   <= kout_d;
    if (state_q == mqlnp_pkg::S_DONE && out_free) begin
      out_status_q <= status_q;
      out_dout_q   <= dout_q;
      out_kout_q   <= kout_q;
      out_count_q  <= mqlnp_pkg::COUNT_W'(qc_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_dout_q;
  assign key_out_o   = out_kout_q;
  assign count_o     = out_count_q;

  mqlnp_ram #(
    .WIDTH (NW),
    .DEPTH (NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  mqlnp_ram #(
    .WIDTH (DW),
    .DEPTH (NODES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  mqlnp_ram #(
    .WIDTH (QRW),
    .DEPTH (QUEUES)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qram_we),
    .waddr_i (qa_q),
    .wdata_i (qram_wdata),
    .raddr_i (qram_raddr),
    .rdata_o (qram_rdata)
  );

  // an empty free list means every never-used node is gone
  `MQLNP_ASSERT(a_fresh_on_free_list, clk_i, rst_ni, (free_head_q == NIL) |-> (fresh_q == '0))
  `MQLNP_ASSERT(a_accept_reads_queue, clk_i, rst_ni, accept |=> (state_q == mqlnp_pkg::S_QRD))
  `MQLNP_ASSERT_NEVER(a_walk_empty_queue, clk_i, rst_ni, (state_q == mqlnp_pkg::S_WALK) && (qc_q == '0))
  `MQLNP_ASSERT(a_done_delivers, clk_i, rst_ni, ((state_q == mqlnp_pkg::S_DONE) && out_free) |=> out_valid_q)

endmodule

>>> verif/pool_checker.sv
`timescale 1ns / 1ps
module pool_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic [mqlnp_pkg::FUNC_W-1:0]      func_i,
  input  logic [mqlnp_pkg::QID_W-1:0]       queue_id_i,
  input  logic [mqlnp_pkg::TAG_W-1:0]       data_tag_i,
  input  logic [mqlnp_pkg::KEY_W-1:0]       sort_key_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [mqlnp_pkg::STATUS_W-1:0]    status_o,
  input  logic [mqlnp_pkg::TAG_W-1:0]       data_out_o,
  input  logic [mqlnp_pkg::KEY_W-1:0]       key_out_o,
  input  logic [mqlnp_pkg::COUNT_W-1:0]     count_o,
  input  logic                              cfg_we_i,
  input  logic [mqlnp_pkg::MASK_W-1:0]      cfg_wdata_i,
  output int                                fail_count,
  output int                                pending_count
);
  import mqlnp_pkg::*;

  localparam int NN = 32;
  localparam int NQ = 4;
  localparam logic [5:0] NIL = 6'(NN);

  typedef struct packed {
    status_e     status;
    logic [31:0] tag;
    logic [31:0] key;
    logic [5:0]  count;
  } pool_result_t;

  pool_result_t expected_results[$];

  logic [5:0]  nxt [NN];
  logic [31:0] tags [NN];
  logic [31:0] keys [NN];
  logic [5:0]  free_top;
  logic [5:0]  qhead [NQ];
  logic [5:0]  qtail [NQ];
  logic [5:0]  qcnt [NQ];
  logic [3:0]  mask;

  function automatic bit valid_node(logic [5:0] n);
    return n < NN;
  endfunction

  function automatic void release_node(logic [5:0] n);
    nxt[n] = free_top;
    free_top = n;
  endfunction

  function automatic pool_result_t apply_op(func_e f, int q, logic [31:0] tg, logic [31:0] ky);
    pool_result_t r;
    logic [5:0] nn, prev, cur, h;
    int steps;
    r = '{status: ST_OK, tag: '0, key: '0, count: '0};
    prev = NIL;
    steps = 0;
    case (f)
      FUNC_ENQ: begin
        nn = free_top;
        if (!valid_node(nn)) begin
          r.status = ST_NO_FREE;
        end else begin
          free_top = nxt[nn];
          tags[nn] = tg;
          keys[nn] = ky;
          nxt[nn] = NIL;
          if (qcnt[q] == 0 || !valid_node(qhead[q])) begin
            qhead[q] = nn;
            qtail[q] = nn;
            qcnt[q] = 1;
          end else if (!mask[q]) begin
            if (valid_node(qtail[q])) nxt[qtail[q]] = nn;
            qtail[q] = nn;
            qcnt[q] += 1;
          end else begin
            cur = qhead[q];
            while (valid_node(cur) && steps < NN && ky >= keys[cur]) begin
              prev = cur;
              cur = nxt[cur];
              steps++;
            end
            nxt[nn] = cur;
            if (!valid_node(prev)) begin
              qhead[q] = nn;
            end else begin
              nxt[prev] = nn;
              if (!valid_node(cur)) qtail[q] = nn;
            end
            qcnt[q] += 1;
          end
        end
      end
      FUNC_REMOVE: begin
        cur = qhead[q];
        while (valid_node(cur) && steps < NN && tags[cur] != tg) begin
          prev = cur;
          cur = nxt[cur];
          steps++;
        end
        if (!valid_node(cur) || steps >= NN) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (!valid_node(prev)) qhead[q] = nxt[cur];
          else nxt[prev] = nxt[cur];
          if (qtail[q] == cur) qtail[q] = prev;
          if (qcnt[q] > 0) qcnt[q] -= 1;
          release_node(cur);
        end
      end
      default: begin
        h = qhead[q];
        if (qcnt[q] == 0 || !valid_node(h)) begin
          r.status = ST_EMPTY;
        end else begin
          r.tag = tags[h];
          r.key = keys[h];
          if (f == FUNC_DEQ) begin
            qhead[q] = nxt[h];
            qcnt[q] -= 1;
            if (!valid_node(qhead[q])) begin
              qtail[q] = NIL;
              qcnt[q] = 0;
            end
            release_node(h);
          end
        end
      end
    endcase
    r.count = qcnt[q];
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t want, got;
    if (!rst_ni) begin
      free_top = NIL;
      for (int i = 0; i < NN; i++) begin
        tags[i] = '0;
        keys[i] = '0;
        release_node(6'(i));
      end
      for (int i = 0; i < NQ; i++) begin
        qhead[i] = NIL;
        qtail[i] = NIL;
        qcnt[i] = '0;
      end
      mask = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      // Compare output first: a result never belongs to the same-edge input.
      if (out_valid_o && out_ready_i) begin
        got = '{status: status_e'(status_o), tag: data_out_o, key: key_out_o, count: count_o};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (in_valid_i && in_ready_o)
        expected_results.push_back(apply_op(func_e'(func_i), int'(queue_id_i), data_tag_i,
                                            sort_key_i));
      if (cfg_we_i) mask = cfg_wdata_i;
    end
  end
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mqlnp_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i = '0;
  logic [QID_W-1:0]    queue_id_i = '0;
  logic [TAG_W-1:0]    data_tag_i = '0;
  logic [KEY_W-1:0]    sort_key_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [TAG_W-1:0]    data_out_o;
  logic [KEY_W-1:0]    key_out_o;
  logic [COUNT_W-1:0]  count_o;
  logic                cfg_we_i = 1'b0;
  logic [MASK_W-1:0]   cfg_wdata_i = '0;
  int                  fail_count;
  int                  pending_count;
  bit                  sink_hold = 1'b0;
  int                  live_tags[$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  multi_queue_linked_node_pool uut (.*);
  pool_checker chk (.*);

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Receiver: random stalls, plus one long hold-off requested by the stimulus.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_op(func_e f, logic [1:0] q, logic [31:0] tg, logic [31:0] ky);
    in_valid_i <= 1'b1;
    func_i <= f;
    queue_id_i <= q;
    data_tag_i <= tg;
    sort_key_i <= ky;
    do @(posedge clk_i); while (!in_ready_o);
    if (f == FUNC_ENQ) live_tags.push_back(int'(tg));
  endtask

  task automatic pause_sender();
    int g;
    g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic set_mask(logic [3:0] m);
    in_valid_i <= 1'b0;
    // let the checker record the last accepted transaction first
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_op(int bias);
    int r;
    logic [31:0] tg;
    logic [31:0] ky;
    r = $urandom_range(0, 99);
    ky = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 7));
    tg = ($urandom_range(0, 2) == 0) ? $urandom() : 32'($urandom_range(0, 15));
    if (r < bias) begin
      send_op(FUNC_ENQ, 2'($urandom_range(0, 3)), tg, ky);
    end else if (r < bias + 20) begin
      send_op(FUNC_DEQ, 2'($urandom_range(0, 3)), tg, ky);
    end else if (r < bias + 35) begin
      if (live_tags.size() > 0 && $urandom_range(0, 3) != 0)
        tg = 32'(live_tags[$urandom_range(0, live_tags.size() - 1)]);
      send_op(FUNC_REMOVE, 2'($urandom_range(0, 3)), tg, ky);
    end else begin
      send_op(FUNC_PEEK, 2'($urandom_range(0, 3)), tg, ky);
    end
    pause_sender();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty queue, extremes, sorted ties, absent tag, mode change.
    send_op(FUNC_DEQ, 2'd0, 32'h0, 32'h0);
    send_op(FUNC_PEEK, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FUNC_REMOVE, 2'd1, 32'h1234, 32'h0);
    send_op(FUNC_ENQ, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FUNC_ENQ, 2'd0, 32'h0, 32'h0);
    send_op(FUNC_PEEK, 2'd0, 32'h0, 32'h0);
    set_mask(4'hF);
    send_op(FUNC_ENQ, 2'd0, 32'hA5A5_5A5A, 32'h8000_0000);
    send_op(FUNC_ENQ, 2'd1, 32'h11, 32'd5);
    send_op(FUNC_ENQ, 2'd1, 32'h22, 32'd5);
    send_op(FUNC_ENQ, 2'd1, 32'h33, 32'd1);
    send_op(FUNC_ENQ, 2'd1, 32'h44, 32'hFFFF_FFFF);
    send_op(FUNC_REMOVE, 2'd1, 32'h22, 32'h0);
    send_op(FUNC_REMOVE, 2'd1, 32'h99, 32'h0);
    send_op(FUNC_DEQ, 2'd1, 32'h0, 32'h0);
    send_op(FUNC_DEQ, 2'd0, 32'h0, 32'h0);
    // Fill the pool and overflow it while the receiver holds off.
    sink_hold = 1'b1;
    for (int i = 0; i < 34; i++) send_op(FUNC_ENQ, 2'(i), 32'(i), $urandom());
    set_mask(4'h0);
    for (int i = 0; i < 40; i++) send_op(FUNC_DEQ, 2'(i), 32'h0, 32'h0);
    // Random phases with several mask settings.
    for (int p = 0; p < 6; p++) begin
      set_mask(4'($urandom()));
      for (int i = 0; i < 230; i++) random_op((p % 2) ? 55 : 35);
    end
    set_mask(4'hA);
    for (int i = 0; i < 20; i++) random_op(60);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
